// ----- hw/rtl/arbug_pkg.sv -----
package arbug_pkg;

    localparam int DEFAULT_RING_DEPTH  = 4096;
    localparam int DEFAULT_PACKET_SIZE = 64;
    localparam int MAX_READ            = 64;
    localparam int MUTE_PACKETS        = 256;
    localparam int REFILL_DIV_FAST     = 32;
    localparam int REFILL_DIV_SLOW     = 400;

    // func codes carried on s_tuser
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic REG_REFILL_MODE = 1'b0;

    typedef struct packed {
        logic pkt_wr;
        logic mute_set;
        logic copy_rd;
        logic rd_start;
        logic rd_issue;
        logic out_load;
    } arbug_cmd_t;

    typedef struct packed {
        logic pkt_full;
        logic ring_nearly_full;
        logic copy_last;
        logic rd_zero;
        logic out_free;
        logic rd_last;
    } arbug_status_t;

endpackage

// ----- hw/rtl/arbug_ctrl.sv -----
module arbug_ctrl
    import arbug_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    func,
    input  arbug_status_t status,
    output arbug_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_COPY     = 3'd1;
    localparam logic [2:0] ST_COPY_END = 3'd2;
    localparam logic [2:0] ST_RD_ISSUE = 3'd3;
    localparam logic [2:0] ST_RD_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_WRITE: begin
                            cmd.pkt_wr = 1'b1;
                            // a full packet goes to the ring unless space is short
                            if (status.pkt_full && !status.ring_nearly_full) begin
                                state_next = ST_COPY;
                            end
                        end
                        FUNC_READ: begin
                            if (!status.rd_zero) begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_RD_ISSUE;
                            end
                        end
                        FUNC_CLEAR: begin
                            cmd.mute_set = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                cmd.copy_rd = 1'b1;
                if (status.copy_last) begin
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                // last ring write lands this cycle
                state_next = ST_IDLE;
            end
            ST_RD_ISSUE: begin
                if (status.out_free) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_RD_LOAD;
                end
            end
            ST_RD_LOAD: begin
                cmd.out_load = 1'b1;
                if (status.rd_last) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RD_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/arbug_dp.sv -----
module arbug_dp
    import arbug_pkg::*;
#(
    parameter int RING_DEPTH  = DEFAULT_RING_DEPTH,
    parameter int PACKET_SIZE = DEFAULT_PACKET_SIZE
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  arbug_cmd_t    cmd,
    output arbug_status_t status,
    input  logic [31:0]   in_left,
    input  logic [31:0]   in_right,
    input  logic [6:0]    read_count,
    input  logic          refill_mode,
    output logic [31:0]   out_left,
    output logic [31:0]   out_right,
    output logic          out_silence,
    output logic          out_last,
    output logic          out_valid,
    input  logic          out_ready
);

    localparam int AW           = $clog2(RING_DEPTH);
    localparam int PW           = $clog2(PACKET_SIZE);
    localparam int LVL_FAST     = RING_DEPTH / REFILL_DIV_FAST;
    localparam int LVL_SLOW     = RING_DEPTH / REFILL_DIV_SLOW;
    localparam int REFILL_FAST  = ((LVL_FAST + PACKET_SIZE - 1) / PACKET_SIZE) * PACKET_SIZE;
    localparam int REFILL_SLOW  = ((LVL_SLOW + PACKET_SIZE - 1) / PACKET_SIZE) * PACKET_SIZE;
    localparam int FULL_LEVEL   = RING_DEPTH - PACKET_SIZE;

    logic [63:0]   ring_mem [RING_DEPTH];
    logic [63:0]   pkt_mem  [PACKET_SIZE];

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [PW-1:0] pf_reg;
    logic [PW-1:0] cp_reg;
    logic [8:0]    mute_reg;
    logic          frozen_reg;
    logic          zero_pkt_reg;
    logic [63:0]   pkt_q_reg;
    logic          pkt_qv_reg;
    logic [63:0]   ring_q_reg;
    logic          rd_real_reg;
    logic [6:0]    n_reg;
    logic [6:0]    real_reg;
    logic [6:0]    k_reg;
    logic [31:0]   out_left_reg;
    logic [31:0]   out_right_reg;
    logic          out_silence_reg;
    logic          out_last_reg;
    logic          out_valid_reg;

    logic [AW:0]   fill_wide;
    logic [AW-1:0] fill;
    logic [AW:0]   refill_lvl;
    logic [6:0]    n_sat;
    logic          above_refill;
    logic          short_data;
    logic [6:0]    real_next;
    logic          frozen_next;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] pkt_inc(input logic [PW-1:0] p);
        return (p == PW'(PACKET_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (wp_reg >= rp_reg) begin
            fill_wide = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            fill_wide = {1'b0, wp_reg} + (AW+1)'(RING_DEPTH) - {1'b0, rp_reg};
        end
    end
    assign fill = fill_wide[AW-1:0];

    assign refill_lvl   = refill_mode ? (AW+1)'(REFILL_FAST) : (AW+1)'(REFILL_SLOW);
    assign n_sat        = (read_count > 7'(MAX_READ)) ? 7'(MAX_READ) : read_count;
    assign above_refill = ({1'b0, fill} >= refill_lvl);
    assign short_data   = (fill < AW'(n_sat));

    // frozen holds silence until the refill level; a short ring freezes again
    always_comb begin
        real_next   = n_sat;
        frozen_next = 1'b0;
        if (frozen_reg && !above_refill) begin
            real_next   = '0;
            frozen_next = 1'b1;
        end else if (short_data) begin
            real_next   = fill[6:0];
            frozen_next = 1'b1;
        end
    end

    assign status.pkt_full         = (pf_reg == PW'(PACKET_SIZE - 1));
    assign status.ring_nearly_full = ({1'b0, fill} >= (AW+1)'(FULL_LEVEL));
    assign status.copy_last        = (cp_reg == PW'(PACKET_SIZE - 1));
    assign status.rd_zero          = (n_sat == '0);
    assign status.out_free         = !out_valid_reg || out_ready;
    assign status.rd_last          = (k_reg == n_reg - 7'd1);

    always_ff @(posedge aclk) begin
        if (cmd.pkt_wr) begin
            pkt_mem[pf_reg] <= {in_right, in_left};
        end
        if (cmd.copy_rd) begin
            pkt_q_reg <= pkt_mem[cp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_qv_reg) begin
            ring_mem[wp_reg] <= zero_pkt_reg ? '0 : pkt_q_reg;
        end
        if (cmd.rd_issue) begin
            ring_q_reg <= ring_mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_left_reg    <= rd_real_reg ? ring_q_reg[31:0]  : '0;
            out_right_reg   <= rd_real_reg ? ring_q_reg[63:32] : '0;
            out_silence_reg <= !rd_real_reg;
            out_last_reg    <= status.rd_last;
        end
        if (cmd.rd_start) begin
            n_reg    <= n_sat;
            real_reg <= real_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            pf_reg        <= '0;
            cp_reg        <= '0;
            mute_reg      <= '0;
            frozen_reg    <= 1'b0;
            zero_pkt_reg  <= 1'b0;
            pkt_qv_reg    <= 1'b0;
            rd_real_reg   <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pkt_qv_reg <= cmd.copy_rd;
            if (cmd.pkt_wr) begin
                pf_reg <= pkt_inc(pf_reg);
                if (status.pkt_full) begin
                    // silence the completed packet while a mute runs
                    zero_pkt_reg <= (mute_reg != '0);
                    if (mute_reg != '0) begin
                        mute_reg <= mute_reg - 9'd1;
                    end
                end
            end
            if (cmd.mute_set) begin
                mute_reg <= 9'(MUTE_PACKETS);
            end
            if (cmd.copy_rd) begin
                cp_reg <= pkt_inc(cp_reg);
            end
            if (pkt_qv_reg) begin
                wp_reg <= ring_inc(wp_reg);
            end
            if (cmd.rd_start) begin
                frozen_reg <= frozen_next;
                k_reg      <= '0;
            end
            if (cmd.rd_issue) begin
                rd_real_reg <= (k_reg < real_reg);
                if (k_reg < real_reg) begin
                    rp_reg <= ring_inc(rp_reg);
                end
            end
            if (cmd.out_load) begin
                k_reg         <= k_reg + 7'd1;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_left    = out_left_reg;
    assign out_right   = out_right_reg;
    assign out_silence = out_silence_reg;
    assign out_last    = out_last_reg;
    assign out_valid   = out_valid_reg;

endmodule

// ----- hw/rtl/audio_ring_buffer_underrun_guard.sv -----
// Write and clear transfers complete on acceptance; a write that completes a packet
// then copies it into the ring, unless the ring is nearly full (packet store read port).
// A read request of N samples does a ring read then an output register load per sample,
// waiting while the output register is held; no new transfer is taken until it ends.
// aresetn is synchronous, active low: pointers, counts, mute and freeze state clear;
// the ring and packet stores are not cleared and need no clearing pass.
module audio_ring_buffer_underrun_guard
    import arbug_pkg::*;
#(
    parameter int RING_DEPTH  = DEFAULT_RING_DEPTH,
    parameter int PACKET_SIZE = DEFAULT_PACKET_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // in_left[31:0], in_right[63:32], read_count[70:64], pad
    input  logic [1:0]  s_tuser,  // func[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_left[31:0], out_right[63:32]
    output logic [0:0]  m_tuser,  // is_silence[0]
    output logic        m_tlast
);

    arbug_cmd_t    cmd;
    arbug_status_t status;
    logic          refill_mode_reg;
    logic          reg_hit;
    logic [31:0]   out_left;
    logic [31:0]   out_right;
    logic          out_silence;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_REFILL_MODE);
    assign prdata  = reg_hit ? {31'b0, refill_mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refill_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            refill_mode_reg <= pwdata[0];
        end
    end

    arbug_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    arbug_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .PACKET_SIZE (PACKET_SIZE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_left     (s_tdata[31:0]),
        .in_right    (s_tdata[63:32]),
        .read_count  (s_tdata[70:64]),
        .refill_mode (refill_mode_reg),
        .out_left    (out_left),
        .out_right   (out_right),
        .out_silence (out_silence),
        .out_last    (m_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = {out_right, out_left};
    assign m_tuser = out_silence;

endmodule
